// ===== hdl/atan2_odl_pkg.sv =====
// Package for the 8-bit octant arctangent block.
// Holds the controller state type, register indexes and angle constants.
// No dependencies.
`timescale 1ns / 1ps

package atan2_odl_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // configuration register indexes
   localparam logic CSR_TABLE_LOW  = 1'b0;
   localparam logic CSR_TABLE_HIGH = 1'b1;

   localparam logic [7:0] ANGLE_DIAGONAL = 8'h20;
   localparam logic [7:0] ANGLE_QUARTER  = 8'h40;
   localparam logic [7:0] ANGLE_HALF     = 8'h80;

   localparam int unsigned DIV_STEPS = 4;

endpackage

// ===== hdl/atan2_octant_divide_lookup.sv =====
// Top level of the 8-bit octant arctangent block.
// Depends on atan2_odl_pkg.
//
//   channel | ports                        | payload (lowest bit up)
//   --------+------------------------------+---------------------------------
//   input   | req_tvalid/tready/tdata[15:0]| dx[7:0], dy[15:8], signed
//   result  | rsp_tvalid/tready/tdata[7:0] | angle[7:0], 256 units per turn
//   config  | csr_valid/ready/index/data   | 0: table entries 0-7, 1: 8-15
//
// One transaction at a time. A divide takes one quotient bit per cycle in a
// shared compare/subtract stage; the divide steps are followed by a finish
// state that loads the result register (equal magnitudes skip the divide).
// A stalled result holds in the output register; the finish state waits for it
// to drain. Synchronous reset clears the table, quotient history and control.
`timescale 1ns / 1ps

module atan2_octant_divide_lookup
   import atan2_odl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // dx[7:0], dy[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // angle[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   state_type   state_ff, state_in;
   logic [63:0] table_low_ff, table_high_ff;
   logic [7:0]  quot_ff, quot_in;       // quotient history shift register
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  den_ff, den_in;
   logic        carry_ff, carry_in;
   logic [1:0]  step_ff, step_in;
   logic        swap_ff, neg_x_ff, neg_y_ff, equal_ff;
   logic [7:0]  angle_ff, angle_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        accept, step_en, finish_load, rsp_free;
   logic [7:0]  dx, dy, mag_x, mag_y;
   logic [7:0]  shifted;
   logic [8:0]  diff;
   logic [3:0]  tbl_idx;
   logic [127:0] tbl_all;
   logic [7:0]  entry, oct_angle, angle_x;

   assign dx     = req_tdata[7:0];
   assign dy     = req_tdata[15:8];
   assign mag_x  = dx[7] ? (~dx + 8'd1) : dx;
   assign mag_y  = dy[7] ? (~dy + 8'd1) : dy;
   assign accept = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (mag_x == mag_y) ? ST_FINISH : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == 2'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready  = 1'b0;
      step_en     = 1'b0;
      finish_load = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready  = 1'b1;
         ST_DIVIDE: step_en     = 1'b1;
         ST_FINISH: finish_load = rsp_free;
         default: begin
         end
      endcase
   end

   // one restoring divide step: history msb shifts into the remainder
   assign shifted = {rem_ff[6:0], quot_ff[7]};
   assign diff    = {1'b0, shifted} - {1'b0, den_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      carry_in = carry_ff;
      step_in  = step_ff;
      if (accept) begin
         rem_in   = (mag_y > mag_x) ? mag_x : mag_y;
         den_in   = (mag_y > mag_x) ? mag_y : mag_x;
         carry_in = (mag_y > mag_x);
         step_in  = 2'd0;
      end else if (step_en) begin
         quot_in  = {quot_ff[6:0], carry_ff};
         carry_in = !diff[8];
         rem_in   = diff[8] ? shifted : diff[7:0];
         step_in  = step_ff + 2'd1;
      end
   end

   // table lookup and sign folding
   assign tbl_all   = {table_high_ff, table_low_ff};
   assign tbl_idx   = {quot_ff[2:0], carry_ff};
   assign entry     = tbl_all[{tbl_idx, 3'b000} +: 8];
   assign oct_angle = equal_ff ? ANGLE_DIAGONAL :
                      (swap_ff ? (ANGLE_QUARTER - entry) : entry);
   assign angle_x   = neg_x_ff ? (ANGLE_HALF - oct_angle) : oct_angle;

   always_comb begin
      angle_in     = angle_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_load) begin
         angle_in     = neg_y_ff ? (~angle_x + 8'd1) : angle_x;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         table_low_ff  <= '0;
         table_high_ff <= '0;
         quot_ff       <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quot_ff      <= quot_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TABLE_LOW:  table_low_ff  <= csr_data;
               CSR_TABLE_HIGH: table_high_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      carry_ff <= carry_in;
      angle_ff <= angle_in;
      if (accept) begin
         swap_ff  <= (mag_y > mag_x);
         equal_ff <= (mag_y == mag_x);
         neg_x_ff <= dx[7];
         neg_y_ff <= dy[7];
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = angle_ff;

endmodule

// ===== hdl/atan2_odl_checker.sv =====
// Port-level checker for the octant arctangent block, with its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module atan2_odl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one transaction at a time: busy right after an accepted input
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready while divide in flight");

   // ready drops only because a transaction was taken
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("input ready dropped without a transaction");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind atan2_octant_divide_lookup atan2_odl_checker u_atan2_odl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/testbench.sv =====
// Testbench for atan2_octant_divide_lookup: drives dx/dy transactions through the
// stream ports, reloads the arctangent table between phases, and scores every angle.
// Depends on atan2_odl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
   import atan2_odl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER = 400;

   // Predicts angles from its own copy of the table and quotient history.
   class angle_scoreboard;
      logic [63:0] atan_low;
      logic [63:0] atan_high;
      logic [7:0]  quot_hist;
      logic [7:0]  expected_angles[$];
      logic [15:0] pending_inputs[$];
      int errors;

      function new();
         atan_low = '0;
         atan_high = '0;
         quot_hist = '0;
         errors = 0;
      endfunction

      function void set_table(logic idx, logic [63:0] value);
         if (idx == CSR_TABLE_LOW) atan_low = value;
         else atan_high = value;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%t ERROR: %s", $realtime, msg);
      endfunction

      // Restoring divide, num < den; old upper nibble of history shifts into the dividend.
      function logic [7:0] divide_lookup(logic [7:0] num, logic [7:0] den, logic carry);
         logic [7:0] a;
         logic [7:0] q;
         logic c;
         logic spill;
         logic [3:0] idx;
         a = num;
         q = quot_hist;
         c = carry;
         for (int i = 0; i < DIV_STEPS; i++) begin
            spill = q[7];
            q = {q[6:0], c};
            a = {a[6:0], spill};
            c = (a >= den);
            if (c) a = a - den;
         end
         quot_hist = q;
         idx = {q[2:0], c};
         return idx[3] ? atan_high[idx[2:0]*8 +: 8] : atan_low[idx[2:0]*8 +: 8];
      endfunction

      function logic [7:0] predict_angle(logic [7:0] dx, logic [7:0] dy);
         logic [7:0] mx;
         logic [7:0] my;
         logic [7:0] r;
         mx = dx[7] ? 8'(~dx + 8'd1) : dx;
         my = dy[7] ? 8'(~dy + 8'd1) : dy;
         if (mx == my) r = ANGLE_DIAGONAL;
         else if (my < mx) r = divide_lookup(my, mx, 1'b0);
         else r = ANGLE_QUARTER - divide_lookup(mx, my, 1'b1);
         if (dx[7]) r = ANGLE_HALF - r;
         if (dy[7]) r = 8'(~r + 8'd1);
         return r;
      endfunction

      function void note_input(logic [15:0] data);
         expected_angles.push_back(predict_angle(data[7:0], data[15:8]));
         pending_inputs.push_back(data);
      endfunction

      function void check_angle(logic [7:0] actual);
         logic [7:0] want;
         logic [15:0] src;
         if (expected_angles.size() == 0) begin
            report($sformatf("unexpected angle %02h", actual));
            return;
         end
         want = expected_angles.pop_front();
         src = pending_inputs.pop_front();
         if (actual !== want)
            report($sformatf("dx=%0d dy=%0d: angle expected %02h, got %02h",
                             $signed(src[7:0]), $signed(src[15:8]), want, actual));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_TABLE_LOW;
   logic [63:0] csr_data = '0;

   angle_scoreboard sb = new();
   int inputs_accepted = 0;
   int idle_cycles = 0;

   atan2_octant_divide_lookup DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, occasionally a long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Transaction monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_input(req_tdata);
            inputs_accepted++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_angle(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver: random backpressure, plus one long hold-off so the block stalls its input.
   initial begin
      int r;
      bit held;
      held = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && inputs_accepted >= HOLD_OFF_AFTER) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else if (r < 95) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [7:0] dx, logic [7:0] dy);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {dy, dx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_stream();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_angles.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_table(logic idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_table(idx, value);
      @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [7:0] dx;
      logic [7:0] dy;
      logic [7:0] corner[5];
      int r;
      corner = '{8'h80, 8'hFF, 8'h00, 8'h01, 8'h7F};
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         dx = 8'($urandom_range(0, 255));
         dy = 8'($urandom_range(0, 255));
         if (r < 15) begin
            // equal magnitudes, any sign combination
            dy = $urandom_range(0, 1) ? dx : 8'(~dx + 8'd1);
         end else if (r < 22) begin
            dx = corner[$urandom_range(0, 4)];
            dy = corner[$urandom_range(0, 4)];
         end
         send_item(dx, dy);
      end
   endtask

   initial begin
      logic [7:0] directed_dx[24];
      logic [7:0] directed_dy[24];
      directed_dx = '{8'd0, 8'd127, 8'h80, 8'h80, 8'd127, 8'd127, 8'd0, 8'h80,
                      8'd0, 8'd1, 8'd0, 8'hFF, 8'd0, 8'd100, 8'd37, 8'h9C,
                      8'hDB, 8'd5, 8'hFB, 8'd127, 8'd1, 8'h80, 8'hFF, 8'd64};
      directed_dy = '{8'd0, 8'd127, 8'h80, 8'd127, 8'h80, 8'd0, 8'd127, 8'd0,
                      8'h80, 8'd0, 8'd1, 8'd0, 8'hFF, 8'd37, 8'd100, 8'd37,
                      8'h9C, 8'hFB, 8'd5, 8'd1, 8'd127, 8'hFF, 8'h80, 8'd63};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset table (all zero): corners, folds, equal magnitudes
      for (int i = 0; i < 24; i++) send_item(directed_dx[i], directed_dy[i]);
      send_random(100);
      end_stream();

      // plausible arctangent values; the long hold-off lands in this phase
      write_table(CSR_TABLE_LOW, 64'h11_0F_0D_0A_08_05_03_00);
      write_table(CSR_TABLE_HIGH, 64'h1F_1E_1C_1B_19_18_16_14);
      for (int i = 0; i < 24; i++) send_item(directed_dx[i], directed_dy[i]);
      send_random(300);
      end_stream();

      write_table(CSR_TABLE_LOW, '1);
      write_table(CSR_TABLE_HIGH, '1);
      send_random(150);
      end_stream();

      write_table(CSR_TABLE_LOW, {$urandom, $urandom});
      write_table(CSR_TABLE_HIGH, {$urandom, $urandom});
      send_random(250);
      end_stream();

      write_table(CSR_TABLE_LOW, '0);
      write_table(CSR_TABLE_HIGH, 64'hA5C3_F00F_5A3C_0FF0);
      send_random(250);
      end_stream();

      if (sb.expected_angles.size() != 0)
         sb.report($sformatf("%0d angles never arrived", sb.expected_angles.size()));
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
